// ----- rtl/nmnf_pkg.sv -----
package nmnf_pkg;

	localparam int FW_BITS  = 11;
	localparam int FH_BITS  = 13;
	localparam int THR_BITS = 16;
	localparam int PIX_BITS = 16;
	localparam int TAP_BITS = 4;
	localparam int NUM_TAPS = 9;
	localparam int CENTER_TAP = 4;

	localparam logic [1:0] REG_WIDTH     = 2'd0;
	localparam logic [1:0] REG_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	typedef struct packed {
		logic                        action;
		logic signed [PIX_BITS-1:0]  pixel_value;
	} in_item_t;

	typedef struct packed {
		logic noisy;
		logic frame_end;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                accept;
		logic                clr;
		logic                rd_en;
		logic                acc_en;
		logic [TAP_BITS-1:0] tap;
		logic                div_init;
		logic                div_step;
		logic                emit;
	} cmd_t;

	typedef struct packed {
		logic ready;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/nmnf_ram.sv -----
module nmnf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/nmnf_ctrl.sv -----
module nmnf_ctrl
	import nmnf_pkg::*;
#(
	parameter int PIXEL_BITS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  sts_t   sts,
	output cmd_t   cmd,
	output state_t state
);

	localparam int SW  = PIXEL_BITS + 4;
	localparam int CTW = $clog2(SW + 1);

	state_t state_q, state_d;
	logic [CTW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.tap  = cnt_q[TAP_BITS-1:0];
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				cnt_d = '0;
				if (sts.ready) begin
					cmd.clr = 1'b1;
					state_d = S_READ;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				// issue tap k, accumulate tap k-1 from the registered read
				cmd.rd_en  = (cnt_q < CTW'(NUM_TAPS));
				cmd.acc_en = (cnt_q != '0);
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == CTW'(NUM_TAPS)) begin
					cnt_d   = '0;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_init = (cnt_q == '0);
				cmd.div_step = (cnt_q != '0);
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CTW'(SW)) begin
					cnt_d   = '0;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

// ----- rtl/nmnf_dp.sv -----
module nmnf_dp
	import nmnf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  in_item_t            in_data,
	input  logic                out_stall,
	output logic                out_valid,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [THR_BITS-1:0] cfg_wdata,
	input  cmd_t                cmd,
	output sts_t                sts
);

	localparam int DEPTH = 4 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $clog2(MAX_WIDTH + 1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = FH_BITS;
	localparam int PW    = $clog2(MAX_WIDTH + 4) + 1;
	localparam int XW    = EW + 2;
	localparam int TW    = AW + 2;
	localparam int SW    = PIXEL_BITS + 4;

	logic [FW_BITS-1:0]  fw_q;
	logic [FH_BITS-1:0]  fh_q;
	logic [THR_BITS-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FW_BITS'(1024);
			fh_q  <= FH_BITS'(1024);
			thr_q <= THR_BITS'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:     fw_q  <= cfg_wdata[FW_BITS-1:0];
				REG_HEIGHT:    fh_q  <= cfg_wdata[FH_BITS-1:0];
				REG_THRESHOLD: thr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [EW-1:0] eff_w;
	logic [RW-1:0] eff_h;

	always_comb begin
		if (fw_q == '0) begin
			eff_w = EW'(1);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(fw_q);
		end
		eff_h = (fh_q == '0) ? RW'(1) : fh_q;
	end

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [AW-1:0] in_slot_q, out_slot_q;
	logic [PW-1:0] pend_q;

	logic in_col_last, in_row_last, out_col_last, out_row_last;
	assign in_col_last  = !({1'b0, EW'(in_col_q)} + 1'b1 < {1'b0, eff_w});
	assign in_row_last  = !({1'b0, in_row_q} + 1'b1 < {1'b0, eff_h});
	assign out_col_last = !({1'b0, EW'(out_col_q)} + 1'b1 < {1'b0, eff_w});
	assign out_row_last = !({1'b0, out_row_q} + 1'b1 < {1'b0, eff_h});

	logic store;
	assign store = cmd.accept && !in_data.action;

	logic [PIXEL_BITS-1:0] pix;
	assign pix = PIXEL_BITS'(32'($signed(in_data.pixel_value)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			in_slot_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else begin
			if (store) begin
				in_slot_q <= (in_slot_q == AW'(DEPTH - 1)) ? '0 : in_slot_q + 1'b1;
				pend_q    <= pend_q + 1'b1;
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_last ? '0 : in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_slot_q <= (out_slot_q == AW'(DEPTH - 1)) ? '0 : out_slot_q + 1'b1;
				pend_q     <= pend_q - 1'b1;
				if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_last ? '0 : out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// neighborhood geometry of the next flag to leave
	logic                 tap_in [NUM_TAPS];
	logic signed [XW-1:0] tap_off [NUM_TAPS];
	logic signed [XW-1:0] max_off;

	always_comb begin
		logic signed [RW+1:0] rr;
		logic signed [XW-1:0] cc;
		max_off = '0;
		for (int k = 0; k < NUM_TAPS; k++) begin
			rr = $signed((RW+2)'(out_row_q)) + (RW+2)'(k / 3 - 1);
			cc = $signed(XW'(out_col_q)) + XW'(k % 3 - 1);
			tap_in[k] = (rr >= 0) && (rr < $signed((RW+2)'(eff_h)))
				&& (cc >= 0) && (cc < $signed(XW'(eff_w)));
			tap_off[k] = XW'(k % 3 - 1);
			if (k / 3 == 0) begin
				tap_off[k] = tap_off[k] - $signed(XW'(eff_w));
			end else if (k / 3 == 2) begin
				tap_off[k] = tap_off[k] + $signed(XW'(eff_w));
			end
			if (tap_in[k] && tap_off[k] > max_off) begin
				max_off = tap_off[k];
			end
		end
	end

	assign sts.ready    = $signed({1'b0, pend_q}) > max_off;
	assign sts.out_free = !out_valid || !out_stall;

	logic signed [XW-1:0] off_sel;
	logic                 in_sel;
	logic signed [TW-1:0] tslot;
	logic [AW-1:0]        raddr;

	always_comb begin
		off_sel = '0;
		in_sel  = 1'b0;
		for (int k = 0; k < NUM_TAPS; k++) begin
			if (cmd.tap == TAP_BITS'(k)) begin
				off_sel = tap_off[k];
				in_sel  = tap_in[k];
			end
		end
		tslot = $signed(TW'(out_slot_q)) + TW'(off_sel);
		if (tslot < 0) begin
			tslot = tslot + $signed(TW'(DEPTH));
		end else if (tslot >= $signed(TW'(DEPTH))) begin
			tslot = tslot - $signed(TW'(DEPTH));
		end
		raddr = tslot[AW-1:0];
	end

	logic [PIXEL_BITS-1:0] rdata;

	nmnf_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (store),
		.waddr(in_slot_q),
		.wdata(pix),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic incl_s1, ctr_s1;
	logic signed [SW-1:0]         sum_q;
	logic [3:0]                   cnt_q;
	logic signed [PIXEL_BITS-1:0] centre_q;
	logic [SW-1:0]                quo_q;
	logic [3:0]                   rem_q;
	logic                         neg_q;
	logic [4:0]                   r2;

	assign r2 = {rem_q, quo_q[SW-1]};

	always_ff @(posedge clk) begin
		incl_s1 <= in_sel && (cmd.tap != TAP_BITS'(CENTER_TAP));
		ctr_s1  <= (cmd.tap == TAP_BITS'(CENTER_TAP));
		if (cmd.clr) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.acc_en) begin
			if (incl_s1) begin
				sum_q <= sum_q + SW'($signed(rdata));
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctr_s1) begin
				centre_q <= $signed(rdata);
			end
		end
		if (cmd.div_init) begin
			quo_q <= sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
			rem_q <= '0;
			neg_q <= sum_q[SW-1];
		end else if (cmd.div_step) begin
			// restoring step, one quotient bit per cycle
			if (r2 >= {1'b0, cnt_q}) begin
				rem_q <= 4'(r2 - {1'b0, cnt_q});
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= r2[3:0];
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
	end

	logic signed [SW:0]   mean;
	logic signed [SW+1:0] diff;
	logic [SW+1:0]        absd;
	logic                 flag;

	always_comb begin
		mean = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		diff = (SW+2)'(mean) - (SW+2)'(centre_q);
		absd = diff[SW+1] ? (SW+2)'(-diff) : (SW+2)'(diff);
		flag = (cnt_q != '0) && (absd >= (SW+2)'(thr_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data.noisy     <= flag;
			out_data.frame_end <= out_col_last && out_row_last;
		end
	end

endmodule

// ----- rtl/neighbor_mean_noise_flag.sv -----
// 3x3 neighbor-mean noise flag on a raster pixel stream. Pixels enter in raster order
// (action 0) and one flag per pixel leaves in raster order once all of its in-frame
// neighbors have arrived; drain items (action 1) push out flags still pending after the
// frame's last pixel. A pixel's history lives in a ring RAM of 4*MAX_WIDTH entries. An item
// with no flag ready is only accepted and checked; when a flag leaves, the nine window taps
// are read one per cycle through the single RAM read port, then the neighbor sum is divided
// by the neighbor count one quotient bit per cycle, and the flag waits while the output
// register still holds a stalled flag. A waiting result in the output register does not
// block the next input transfer.
module neighbor_mean_noise_flag
	import nmnf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [THR_BITS-1:0] cfg_wdata
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	nmnf_ctrl #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd),
		.state   (state)
	);

	nmnf_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	a_emit_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !in_xfer)
		else $error("flag emitted during an input transfer");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted flag not presented");

	a_check_after_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state == S_CHECK)
		else $error("input transfer not followed by readiness check");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || !out_stall))
		else $error("flag emitted over a stalled result");

endmodule

// ----- tb/nmnf_checker.sv -----
`timescale 1ns / 100ps

module nmnf_checker
	import nmnf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_item_t            in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [THR_BITS-1:0] cfg_wdata,
	output int                  fail_count,
	output int                  flags_waiting
);

	localparam int RING = 4 * MAX_WIDTH;

	int        history[RING];
	int        wr_slot, rd_slot, backlog;
	int        in_col, in_row, out_col, out_row;
	int        width_reg, height_reg, thr_reg;
	out_item_t flag_q[$];

	function automatic int eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int eff_h();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	// advance a raster position, wrapping at the frame size
	task automatic step_pos(inout int col, inout int row, input int w, input int h);
		if (col + 1 < w) begin
			col++;
		end else begin
			col = 0;
			row = (row + 1 < h) ? row + 1 : 0;
		end
	endtask

	task automatic predict_flag(input in_item_t item);
		int        w, h, rr, cc, off, max_off, sum, cnt, mean, diff, centre;
		out_item_t res;
		logic signed [PIXEL_BITS-1:0] pix;
		w = eff_w();
		h = eff_h();
		if (item.action == 1'b0) begin
			pix = item.pixel_value[PIXEL_BITS-1:0];
			history[wr_slot] = pix;
			wr_slot = (wr_slot + 1) % RING;
			backlog++;
			step_pos(in_col, in_row, w, h);
		end
		if (backlog == 0) return;
		max_off = 0;
		sum = 0;
		cnt = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			rr = out_row + dr;
			if (rr < 0 || rr >= h) continue;
			for (int dc = -1; dc <= 1; dc++) begin
				cc = out_col + dc;
				if (cc < 0 || cc >= w) continue;
				off = dr * w + dc;
				if (off > max_off) max_off = off;
				if (dr != 0 || dc != 0) begin
					sum += history[(rd_slot + RING + off) % RING];
					cnt++;
				end
			end
		end
		// hold until every neighbor has arrived
		if (max_off >= backlog) return;
		centre = history[rd_slot];
		res.noisy = 1'b0;
		if (cnt > 0) begin
			mean = sum / cnt;
			diff = mean - centre;
			if (diff < 0) diff = -diff;
			res.noisy = (diff >= thr_reg);
		end
		res.frame_end = (out_col + 1 >= w) && (out_row + 1 >= h);
		step_pos(out_col, out_row, w, h);
		rd_slot = (rd_slot + 1) % RING;
		backlog--;
		flag_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (history[i]) history[i] = 0;
			wr_slot = 0; rd_slot = 0; backlog = 0;
			in_col = 0; in_row = 0; out_col = 0; out_row = 0;
			width_reg = 1024; height_reg = 1024; thr_reg = 2;
			flag_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (flag_q.size() == 0) begin
					$error("unexpected flag transfer: noisy=%0b frame_end=%0b",
						out_data.noisy, out_data.frame_end);
					fail_count++;
				end else begin
					out_item_t want;
					want = flag_q.pop_front();
					if (out_data.noisy !== want.noisy) begin
						$error("noisy: expected %0b, got %0b", want.noisy, out_data.noisy);
						fail_count++;
					end
					if (out_data.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b",
							want.frame_end, out_data.frame_end);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) predict_flag(in_data);
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:     width_reg = cfg_wdata[FW_BITS-1:0];
					REG_HEIGHT:    height_reg = cfg_wdata[FH_BITS-1:0];
					REG_THRESHOLD: thr_reg = cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	assign flags_waiting = flag_q.size();

endmodule

// ----- tb/tb_neighbor_mean_noise_flag.sv -----
`timescale 1ns / 100ps

module tb_neighbor_mean_noise_flag;
	import nmnf_pkg::*;

	localparam int WATCHDOG = 20000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_data;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [THR_BITS-1:0] cfg_wdata;
	int                  fail_count;
	int                  flags_waiting;
	int                  idle_pct;
	int                  stall_pct;
	int                  quiet_cycles;

	neighbor_mean_noise_flag dut (.*);

	nmnf_checker chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .fail_count(fail_count), .flags_waiting(flags_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog: end the run if nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG) begin
			$display("tb_neighbor_mean_noise_flag: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[THR_BITS-1:0];
		@(posedge clk);
	endtask

	// wait for all flags, then let the block finish any item in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (flags_waiting != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_item(input logic act, input logic [15:0] pix);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{action: act, pixel_value: pix};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_pixel();
		case ($urandom_range(5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	// one frame of pixels, then, when drains is set, enough drains to flush it
	task automatic run_frame(input int w, input int h, input bit drains);
		for (int i = 0; i < w * h; i++) send_item(1'b0, rand_pixel());
		if (drains) begin
			for (int i = 0; i < w + 2; i++) send_item(1'b1, 16'($urandom));
		end
	endtask

	task automatic set_frame(input int w, input int h, input int thr);
		settle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_THRESHOLD, thr);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int w, h;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_wdata = '0;
		idle_pct  = 0;
		stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single pixel, single row, single column, 3x3 with extremes
		set_frame(1, 1, 0);
		send_item(1'b0, 16'h7FFF);
		send_item(1'b1, 16'hFFFF);
		set_frame(4, 1, 1);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h7FFF);
		send_item(1'b0, 16'h0000);
		send_item(1'b0, 16'hFFFF);
		send_item(1'b1, 16'h0);
		send_item(1'b1, 16'h0);
		set_frame(1, 3, 65535);
		run_frame(1, 3, 1);
		set_frame(3, 3, 2);
		send_item(1'b0, 16'h8000);
		for (int i = 0; i < 7; i++) send_item(1'b0, 16'h7FFF);
		send_item(1'b0, 16'h8000);
		for (int i = 0; i < 5; i++) send_item(1'b1, 16'h0);

		// random frames over several idle/stall phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			for (int f = 0; f < 3; f++) begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 6);
				if (f == 0 && ph == 3) begin w = 100; h = 1; end
				if (f == 1 && ph == 3) begin w = 2; h = 40; end
				set_frame(w, h, $urandom_range(3) == 0 ? 65535 : $urandom_range(0, 600));
				run_frame(w, h, 1'b0);
				// back-to-back second frame, no drains between, if w*h <= 40; else drains only
				if (w * h <= 40) run_frame(w, h, 1'b1);
				else for (int i = 0; i < w + 2; i++) send_item(1'b1, 16'h0);
			end
		end
		// register extremes: zero width and height count as one
		set_frame(0, 0, 0);
		run_frame(1, 1, 1);

		settle();
		if (fail_count == 0) begin
			$display("tb_neighbor_mean_noise_flag: done, clean");
		end else begin
			$display("tb_neighbor_mean_noise_flag: done, errors");
		end
		$finish;
	end

endmodule
